// ----- src/mst_pkg.sv -----
// Package for the minimum spanning tree engine: widths, defaults,
// and the command/status structs between controller and datapath. No dependencies.
package mst_pkg;

    localparam int VID_W            = 5;
    localparam int NV_W             = 6;
    localparam int DEF_MAX_VERTICES = 32;
    localparam int DEF_MAX_EDGES    = 64;
    localparam int DEF_WEIGHT_BITS  = 16;
    localparam logic [NV_W-1:0] NV_RESET = 6'd32;

    typedef struct packed {
        logic load;
        logic init_start;
        logic init_step;
        logic scan_start;
        logic scan_step;
        logic advance;
        logic join_set;
        logic sweep_step;
        logic finish;
    } mst_cmd_t;

    typedef struct packed {
        logic init_done;
        logic scan_done;
        logic best_has;
        logic diff;
        logic can_join;
        logic sweep_done;
        logic out_free;
    } mst_sts_t;

endpackage

// ----- src/mst_ctrl.sv -----
// Controller state machine for the minimum spanning tree engine.
// Depends on mst_pkg; drives commands into mst_dpath.
module mst_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_last,
    output logic             in_ready,
    input  mst_pkg::mst_sts_t sts,
    output mst_pkg::mst_cmd_t cmd
);
    import mst_pkg::*;

    typedef enum logic [6:0] {
        S_LOAD  = 7'b0000001,
        S_INIT  = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_FIND  = 7'b0001000,
        S_CMP   = 7'b0010000,
        S_SWEEP = 7'b0100000,
        S_FIN   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_LOAD);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_LOAD:
            begin
                cmd.load = in_valid;
                if (in_valid && in_last)
                begin
                    cmd.init_start = 1'b1;
                    state_next     = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.init_step = 1'b1;
                if (sts.init_done)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done)
                    state_next = sts.best_has ? S_FIND : S_FIN;
            end
            S_FIND:
                state_next = S_CMP;
            S_CMP:
            begin
                if (!sts.diff)
                begin
                    cmd.advance    = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
                else if (sts.can_join)
                begin
                    cmd.join_set = 1'b1;
                    state_next   = S_SWEEP;
                end
            end
            S_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_done)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_LOAD;
                end
            end
            default:
                state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_LOAD;
        else
            state_reg <= state_next;
    end

endmodule

// ----- src/mst_dpath.sv -----
// Datapath for the minimum spanning tree engine: edge store, selection scan,
// component label memory, pending and output words. Depends on mst_pkg.
module mst_dpath #(
    parameter int MAX_VERTICES = mst_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = mst_pkg::DEF_MAX_EDGES,
    parameter int WEIGHT_BITS  = mst_pkg::DEF_WEIGHT_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [mst_pkg::NV_W-1:0]      cfg_data,
    input  logic [mst_pkg::VID_W-1:0]     edge_u,
    input  logic [mst_pkg::VID_W-1:0]     edge_v,
    input  logic signed [WEIGHT_BITS-1:0] edge_weight,
    input  mst_pkg::mst_cmd_t             cmd,
    output mst_pkg::mst_sts_t             sts,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mst_pkg::VID_W-1:0]     tree_u,
    output logic [mst_pkg::VID_W-1:0]     tree_v,
    output logic signed [WEIGHT_BITS-1:0] tree_weight,
    output logic                          edge_valid,
    output logic                          last_result,
    output logic                          edges_dropped
);
    import mst_pkg::*;

    localparam int EA_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int VA_W  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int EC_W  = $clog2(MAX_EDGES + 1);
    localparam int NVE_W = $clog2(MAX_VERTICES + 1);
    localparam int MX    = (MAX_EDGES > MAX_VERTICES) ? MAX_EDGES : MAX_VERTICES;
    localparam int IX_W  = $clog2(MX + 1);

    logic [VID_W-1:0]       mem_u [MAX_EDGES];
    logic [VID_W-1:0]       mem_v [MAX_EDGES];
    logic [WEIGHT_BITS-1:0] mem_w [MAX_EDGES];
    logic [VA_W-1:0]        lbl   [MAX_VERTICES];

    logic [NV_W-1:0]  nv_reg;
    logic [EC_W-1:0]  count_reg;
    logic             drop_reg;
    logic [IX_W-1:0]  idx_reg, idx_d_reg;
    logic             pipe_v_reg;

    logic [VID_W-1:0]              rd_u_reg, rd_v_reg;
    logic signed [WEIGHT_BITS-1:0] rd_w_reg;
    logic [VA_W-1:0]               l0_reg, l1_reg;

    logic                          best_has_reg, prev_has_reg;
    logic [VID_W-1:0]              best_u_reg, best_v_reg;
    logic signed [WEIGHT_BITS-1:0] best_w_reg, prev_w_reg;
    logic [IX_W-1:0]               best_i_reg, prev_i_reg;

    logic                          pend_v_reg;
    logic [VID_W-1:0]              pend_u_reg, pend_v_id_reg;
    logic signed [WEIGHT_BITS-1:0] pend_w_reg;
    logic [VA_W-1:0]               old_reg, new_reg;

    logic                          out_v_reg, out_ev_reg, out_last_reg, out_drop_reg;
    logic [VID_W-1:0]              out_u_reg, out_vv_reg;
    logic signed [WEIGHT_BITS-1:0] out_w_reg;

    logic [NVE_W-1:0] nv_eff;
    logic             in_range, store_ok;
    logic             gt_prev, lt_best, out_free;
    logic [VA_W-1:0]  addr0, addr1;
    logic             lbl_we;
    logic [VA_W-1:0]  lbl_wa, lbl_wd;

    always_comb
    begin
        if (nv_reg == '0)
            nv_eff = NVE_W'(1);
        else if (32'(nv_reg) > 32'(MAX_VERTICES))
            nv_eff = NVE_W'(MAX_VERTICES);
        else
            nv_eff = NVE_W'(nv_reg);
    end

    assign in_range = (32'(edge_u) < 32'(nv_eff)) && (32'(edge_v) < 32'(nv_eff));
    assign store_ok = in_range && (32'(count_reg) < 32'(MAX_EDGES));

    assign gt_prev = !prev_has_reg || (rd_w_reg > prev_w_reg) ||
                     ((rd_w_reg == prev_w_reg) && (idx_d_reg > prev_i_reg));
    assign lt_best = !best_has_reg || (rd_w_reg < best_w_reg);

    assign out_free = !out_v_reg || out_ready;

    assign addr0 = cmd.sweep_step ? VA_W'(idx_reg) : VA_W'(best_u_reg);
    assign addr1 = VA_W'(best_v_reg);

    always_comb
    begin
        lbl_we = 1'b0;
        lbl_wa = VA_W'(idx_reg);
        lbl_wd = VA_W'(idx_reg);
        if (cmd.init_step)
            lbl_we = 1'b1;
        else if (cmd.sweep_step && pipe_v_reg && (l0_reg == old_reg))
        begin
            lbl_we = 1'b1;
            lbl_wa = VA_W'(idx_d_reg);
            lbl_wd = new_reg;
        end
    end

    assign sts.init_done  = (idx_reg == IX_W'(MAX_VERTICES - 1));
    assign sts.scan_done  = (32'(idx_reg) == 32'(count_reg)) && !pipe_v_reg;
    assign sts.best_has   = best_has_reg;
    assign sts.diff       = (l0_reg != l1_reg);
    assign sts.can_join   = !pend_v_reg || out_free;
    assign sts.sweep_done = (idx_reg == IX_W'(MAX_VERTICES)) && !pipe_v_reg;
    assign sts.out_free   = out_free;

    always_ff @(posedge clk)
    begin
        if (cmd.load && store_ok)
        begin
            mem_u[EA_W'(count_reg)] <= edge_u;
            mem_v[EA_W'(count_reg)] <= edge_v;
            mem_w[EA_W'(count_reg)] <= edge_weight;
        end
        rd_u_reg <= mem_u[EA_W'(idx_reg)];
        rd_v_reg <= mem_v[EA_W'(idx_reg)];
        rd_w_reg <= mem_w[EA_W'(idx_reg)];
    end

    always_ff @(posedge clk)
    begin
        if (lbl_we)
            lbl[lbl_wa] <= lbl_wd;
        l0_reg <= lbl[addr0];
        l1_reg <= lbl[addr1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nv_reg       <= NV_RESET;
            count_reg    <= '0;
            drop_reg     <= 1'b0;
            idx_reg      <= '0;
            idx_d_reg    <= '0;
            pipe_v_reg   <= 1'b0;
            best_has_reg <= 1'b0;
            prev_has_reg <= 1'b0;
            pend_v_reg   <= 1'b0;
            out_v_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                nv_reg <= cfg_data;

            if (cmd.load)
            begin
                if (store_ok)
                    count_reg <= count_reg + EC_W'(1);
                else
                    drop_reg <= 1'b1;
            end

            if (out_v_reg && out_ready && !cmd.finish && !(cmd.join_set && pend_v_reg))
                out_v_reg <= 1'b0;

            priority if (cmd.init_start)
            begin
                idx_reg      <= '0;
                prev_has_reg <= 1'b0;
            end
            else if (cmd.scan_start)
            begin
                idx_reg      <= '0;
                pipe_v_reg   <= 1'b0;
                best_has_reg <= 1'b0;
            end
            else if (cmd.init_step)
                idx_reg <= idx_reg + IX_W'(1);
            else if (cmd.scan_step)
            begin
                if (32'(idx_reg) < 32'(count_reg))
                begin
                    pipe_v_reg <= 1'b1;
                    idx_d_reg  <= idx_reg;
                    idx_reg    <= idx_reg + IX_W'(1);
                end
                else
                    pipe_v_reg <= 1'b0;
                if (pipe_v_reg && gt_prev && lt_best)
                begin
                    best_has_reg <= 1'b1;
                    best_u_reg   <= rd_u_reg;
                    best_v_reg   <= rd_v_reg;
                    best_w_reg   <= rd_w_reg;
                    best_i_reg   <= idx_d_reg;
                end
            end
            else if (cmd.sweep_step)
            begin
                if (idx_reg < IX_W'(MAX_VERTICES))
                begin
                    pipe_v_reg <= 1'b1;
                    idx_d_reg  <= idx_reg;
                    idx_reg    <= idx_reg + IX_W'(1);
                end
                else
                    pipe_v_reg <= 1'b0;
            end
            else if (cmd.join_set)
            begin
                idx_reg    <= '0;
                pipe_v_reg <= 1'b0;
            end

            if (cmd.advance || cmd.join_set)
            begin
                prev_has_reg <= 1'b1;
                prev_w_reg   <= best_w_reg;
                prev_i_reg   <= best_i_reg;
            end

            if (cmd.join_set)
            begin
                old_reg <= l0_reg;
                new_reg <= l1_reg;
                if (pend_v_reg)
                begin
                    out_v_reg    <= 1'b1;
                    out_u_reg    <= pend_u_reg;
                    out_vv_reg   <= pend_v_id_reg;
                    out_w_reg    <= pend_w_reg;
                    out_ev_reg   <= 1'b1;
                    out_last_reg <= 1'b0;
                    out_drop_reg <= drop_reg;
                end
                pend_v_reg    <= 1'b1;
                pend_u_reg    <= best_u_reg;
                pend_v_id_reg <= best_v_reg;
                pend_w_reg    <= best_w_reg;
            end

            if (cmd.finish)
            begin
                out_v_reg    <= 1'b1;
                out_u_reg    <= pend_v_reg ? pend_u_reg : '0;
                out_vv_reg   <= pend_v_reg ? pend_v_id_reg : '0;
                out_w_reg    <= pend_v_reg ? pend_w_reg : '0;
                out_ev_reg   <= pend_v_reg;
                out_last_reg <= 1'b1;
                out_drop_reg <= drop_reg;
                pend_v_reg   <= 1'b0;
                count_reg    <= '0;
                drop_reg     <= 1'b0;
            end
        end
    end

    assign out_valid     = out_v_reg;
    assign tree_u        = out_u_reg;
    assign tree_v        = out_vv_reg;
    assign tree_weight   = out_w_reg;
    assign edge_valid    = out_ev_reg;
    assign last_result   = out_last_reg;
    assign edges_dropped = out_drop_reg;

endmodule

// ----- src/minimum_spanning_tree_engine_top.sv -----
// Top level of the minimum spanning tree engine.
// Depends on mst_pkg, mst_ctrl and mst_dpath.
//
//  channel | handshake            | word
//  cfg     | cfg_valid/cfg_ready  | cfg_data (num_vertices)
//  in      | in_valid/in_ready    | edge_u, edge_v, edge_weight, last_edge
//  out     | out_valid/out_ready  | tree_u, tree_v, tree_weight, edge_valid,
//          |                      | last_result, edges_dropped
//
// Edges load one per cycle while the engine is in its load state. After the last
// edge: label init of all MAX_VERTICES labels, then per sorted edge a scan over the
// edge store and a label lookup, and a relabel sweep of the labels per tree edge.
// Reset clears control state; edge store and labels are not cleared.
// A stalled output holds the engine only when a new tree edge or the final word is ready.
module minimum_spanning_tree_engine_top #(
    parameter int MAX_VERTICES = mst_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = mst_pkg::DEF_MAX_EDGES,
    parameter int WEIGHT_BITS  = mst_pkg::DEF_WEIGHT_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mst_pkg::NV_W-1:0]      cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [mst_pkg::VID_W-1:0]     edge_u,
    input  logic [mst_pkg::VID_W-1:0]     edge_v,
    input  logic signed [WEIGHT_BITS-1:0] edge_weight,
    input  logic                          last_edge,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mst_pkg::VID_W-1:0]     tree_u,
    output logic [mst_pkg::VID_W-1:0]     tree_v,
    output logic signed [WEIGHT_BITS-1:0] tree_weight,
    output logic                          edge_valid,
    output logic                          last_result,
    output logic                          edges_dropped
);
    import mst_pkg::*;

    mst_cmd_t cmd;
    mst_sts_t sts;

    assign cfg_ready = 1'b1;

    mst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_last  (last_edge),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mst_dpath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .edge_u        (edge_u),
        .edge_v        (edge_v),
        .edge_weight   (edge_weight),
        .cmd           (cmd),
        .sts           (sts),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .tree_u        (tree_u),
        .tree_v        (tree_v),
        .tree_weight   (tree_weight),
        .edge_valid    (edge_valid),
        .last_result   (last_result),
        .edges_dropped (edges_dropped)
    );

endmodule

// ----- tb/minimum_spanning_tree_engine_top_test.sv -----
// Self-checking test of minimum_spanning_tree_engine_top: edge graphs in, tree edges out,
// checked against an in-bench Kruskal predictor. Depends on mst_pkg and the engine RTL.
`timescale 1ns / 1ps

typedef struct {
    logic [4:0]         u;
    logic [4:0]         v;
    logic signed [15:0] w;
    logic               valid;
    logic               last;
    logic               dropped;
} tree_word_t;

class mst_scoreboard;
    logic [5:0]         nv_reg = mst_pkg::NV_RESET;
    logic [4:0]         st_u [64];
    logic [4:0]         st_v [64];
    logic signed [15:0] st_w [64];
    int                 count = 0;
    logic               dropped = 0;
    tree_word_t         tree_q [$];
    int                 errors = 0;

    function int eff_nv();
        if (nv_reg == 0) return 1;
        if (nv_reg > 32) return 32;
        return nv_reg;
    endfunction

    function void note_edge(logic [4:0] u, logic [4:0] v, logic signed [15:0] w, logic last);
        int ord [64];
        int label [32];
        int i, j, k, lu, lv, found;
        tree_word_t t;
        if (u < eff_nv() && v < eff_nv() && count < 64) begin
            st_u[count] = u;
            st_v[count] = v;
            st_w[count] = w;
            count++;
        end else begin
            dropped = 1;
        end
        if (!last) return;
        for (i = 0; i < count; i++) begin
            j = i;
            while (j > 0 && st_w[ord[j-1]] > st_w[i]) begin
                ord[j] = ord[j-1];
                j--;
            end
            ord[j] = i;
        end
        for (i = 0; i < 32; i++) label[i] = i;
        found = 0;
        for (i = 0; i < count; i++) begin
            k = ord[i];
            lu = label[st_u[k]];
            lv = label[st_v[k]];
            if (lu != lv) begin
                for (j = 0; j < 32; j++)
                    if (label[j] == lv) label[j] = lu;
                t.u = st_u[k];
                t.v = st_v[k];
                t.w = st_w[k];
                t.valid = 1;
                t.last = 0;
                t.dropped = dropped;
                tree_q.insert(tree_q.size(), t);
                found++;
            end
        end
        if (found == 0) begin
            t.u = 0;
            t.v = 0;
            t.w = 0;
            t.valid = 0;
            t.last = 1;
            t.dropped = dropped;
            tree_q.insert(tree_q.size(), t);
        end else begin
            tree_q[tree_q.size()-1].last = 1;
        end
        count = 0;
        dropped = 0;
    endfunction

    function void check_word(tree_word_t a);
        tree_word_t e;
        if (tree_q.size() == 0) begin
            $error("unexpected tree word u=%0d v=%0d w=%0d", a.u, a.v, a.w);
            errors++;
            return;
        end
        e = tree_q.pop_front();
        if (a.u !== e.u) begin $error("tree_u exp %0d got %0d", e.u, a.u); errors++; end
        if (a.v !== e.v) begin $error("tree_v exp %0d got %0d", e.v, a.v); errors++; end
        if (a.w !== e.w) begin $error("tree_weight exp %0d got %0d", e.w, a.w); errors++; end
        if (a.valid !== e.valid)
        begin
            $error("edge_valid exp %0d got %0d", e.valid, a.valid);
            errors++;
        end
        if (a.last !== e.last)
        begin
            $error("last_result exp %0d got %0d", e.last, a.last);
            errors++;
        end
        if (a.dropped !== e.dropped)
        begin
            $error("edges_dropped exp %0d got %0d", e.dropped, a.dropped);
            errors++;
        end
    endfunction
endclass

module minimum_spanning_tree_engine_top_test;
    localparam int STALL_LIMIT = 30000;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               cfg_valid = 0;
    logic               cfg_ready;
    logic [5:0]         cfg_data = 0;
    logic               in_valid = 0;
    logic               in_ready;
    logic [4:0]         edge_u = 0;
    logic [4:0]         edge_v = 0;
    logic signed [15:0] edge_weight = 0;
    logic               last_edge = 0;
    logic               out_valid;
    logic               out_ready = 0;
    logic [4:0]         tree_u;
    logic [4:0]         tree_v;
    logic signed [15:0] tree_weight;
    logic               edge_valid;
    logic               last_result;
    logic               edges_dropped;

    mst_scoreboard sb = new();
    bit  calm = 0;
    bit  hold_req = 0;
    int  idle_cnt = 0;
    int  items = 0;

    minimum_spanning_tree_engine_top DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .edge_u(edge_u), .edge_v(edge_v), .edge_weight(edge_weight), .last_edge(last_edge),
        .out_valid(out_valid), .out_ready(out_ready),
        .tree_u(tree_u), .tree_v(tree_v), .tree_weight(tree_weight),
        .edge_valid(edge_valid), .last_result(last_result), .edges_dropped(edges_dropped)
    );

    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    // receiver
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (hold_req) begin
                out_ready <= 0;
                repeat (400) @(posedge clk);
                hold_req = 0;
            end else begin
                out_ready <= calm || ($urandom_range(0, 99) >= 11);
            end
        end
    end

    always @(posedge clk)
    begin
        tree_word_t a;
        if (out_valid && out_ready) begin
            a.u = tree_u;
            a.v = tree_v;
            a.w = tree_weight;
            a.valid = edge_valid;
            a.last = last_result;
            a.dropped = edges_dropped;
            sb.check_word(a);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt > STALL_LIMIT) begin
            $display("minimum_spanning_tree_engine_top_test: FAIL");
            $finish;
        end
    end

    task automatic send_edge(logic [4:0] u, logic [4:0] v, logic signed [15:0] w, logic last);
        if (!calm && $urandom_range(0, 99) < 11) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1;
        edge_u <= u;
        edge_v <= v;
        edge_weight <= w;
        last_edge <= last;
        do @(posedge clk); while (!in_ready);
        sb.note_edge(u, v, w, last);
        items++;
    endtask

    task automatic drain();
        while (sb.tree_q.size() > 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_nv(logic [5:0] val);
        in_valid <= 0;
        drain();
        cfg_valid <= 1;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 0;
        sb.nv_reg = val;
    endtask

    task automatic send_graph(int n);
        int i, nv;
        logic [4:0] u, v;
        logic signed [15:0] w;
        nv = sb.eff_nv();
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 8) begin
                u = $urandom;
                v = $urandom;
            end else begin
                u = $urandom_range(0, nv - 1);
                v = $urandom_range(0, nv - 1);
            end
            w = ($urandom_range(0, 1)) ? 16'($urandom) : 16'($signed($urandom_range(0, 6)) - 3);
            send_edge(u, v, w, i == n - 1);
        end
    endtask

    initial
    begin
        int i, n;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // extremes, ties, self loop
        send_edge(31, 0, 16'sh7fff, 0);
        send_edge(0, 1, -16'sd32768, 0);
        send_edge(5, 5, -16'sd40, 0);
        send_edge(1, 2, 0, 0);
        send_edge(2, 0, 0, 0);
        send_edge(31, 30, 16'sh7fff, 1);
        send_edge(7, 7, 3, 1);
        write_nv(5);
        send_edge(7, 1, 1, 0);
        send_edge(4, 3, 2, 1);
        write_nv(0);
        send_edge(0, 1, 9, 0);
        send_edge(0, 0, 9, 1);
        write_nv(63);
        hold_req = 1;
        for (i = 0; i < 70; i++)
            send_edge(i % 32, (i * 7 + 1) % 32, 16'(i % 5), i == 69);
        send_graph(3);
        write_nv(1);
        send_graph(2);
        write_nv(32);
        send_edge(31, 31, 0, 1);
        while (items < 200) begin
            if ($urandom_range(0, 5) == 0) begin
                case ($urandom_range(0, 3))
                    0: write_nv(2);
                    1: write_nv(32);
                    2: write_nv($urandom_range(3, 31));
                    default: write_nv(6'($urandom));
                endcase
            end
            calm = (items > 100 && items < 140);
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 66) : $urandom_range(1, 10);
            if (n > 210 - items)
                n = 210 - items;
            send_graph(n);
        end
        calm = 0;
        in_valid <= 0;
        while (sb.tree_q.size() > 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
            $display("minimum_spanning_tree_engine_top_test: PASS");
        else
            $display("minimum_spanning_tree_engine_top_test: FAIL");
        $finish;
    end
endmodule
